// ===== hw/rtl/mksg_pkg.sv =====
// shared constants and codes for the markov k-mer sequence generator
package mksg_pkg;

   // fixed field widths of the channels
   localparam int ROW_FIELD_BITS    = 8;
   localparam int WEIGHT_FIELD_BITS = 16;
   localparam int DRAW_FIELD_BITS   = 32;
   localparam int CODE_BITS         = 3;
   localparam int CSR_INDEX_BITS    = 2;
   localparam int CSR_DATA_BITS     = 32;

   // action codes
   localparam logic ACT_LOAD     = 1'b0;
   localparam logic ACT_GENERATE = 1'b1;

   // base codes
   localparam logic [CODE_BITS-1:0] CODE_A = 3'd0;
   localparam logic [CODE_BITS-1:0] CODE_T = 3'd3;
   localparam logic [CODE_BITS-1:0] CODE_N = 3'd4;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_KMER   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BURNIN_COUNT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OUT_LENGTH   = 2'd2;

endpackage

// ===== hw/rtl/mksg_if.sv =====
// valid/ready channel interfaces for requests, responses and register writes
interface mksg_req_if import mksg_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic                          action;
   logic [ROW_FIELD_BITS-1:0]     row_index;
   logic [1:0]                    base_index;
   logic [WEIGHT_FIELD_BITS-1:0]  weight;
   logic [DRAW_FIELD_BITS-1:0]    random_draw;

   modport source (output valid, action, row_index, base_index, weight, random_draw,
                   input ready);
   modport sink   (input valid, action, row_index, base_index, weight, random_draw,
                   output ready);
endinterface

interface mksg_rsp_if import mksg_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CODE_BITS-1:0] base_code;
   logic                 last_base;

   modport source (output valid, base_code, last_base, input ready);
   modport sink   (input valid, base_code, last_base, output ready);
endinterface

interface mksg_cfg_if import mksg_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/mksg_ram.sv =====
// generic single-write, single-read ram with registered read data
module mksg_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/mksg_pick.sv =====
// exact cumulative-weight comparison that picks the next base of a row
module mksg_pick import mksg_pkg::*; #(
   parameter int WEIGHT_BITS = 16,
   parameter int DRAW_BITS   = 32
) (
   input  logic [4*WEIGHT_BITS-1:0] row,
   input  logic [DRAW_BITS-1:0]     draw,
   output logic [CODE_BITS-1:0]     code
);

   localparam int SUM_BITS  = WEIGHT_BITS + 2;
   localparam int PROD_BITS = DRAW_BITS + SUM_BITS;

   logic [SUM_BITS-1:0]  cum [4];
   logic [PROD_BITS-1:0] prod;

   // running sums, the last one is the row total
   always_comb begin
      cum[0] = SUM_BITS'(row[0 +: WEIGHT_BITS]);
      for (int b = 1; b < 4; b++) begin
         cum[b] = cum[b-1] + SUM_BITS'(row[b*WEIGHT_BITS +: WEIGHT_BITS]);
      end
   end

   assign prod = PROD_BITS'(draw) * PROD_BITS'(cum[3]);

   always_comb begin
      code = CODE_T;
      // scan from the top so the first match wins
      for (int b = 3; b >= 0; b--) begin
         if ({cum[b], {DRAW_BITS{1'b0}}} > prod) begin
            code = CODE_BITS'(b);
         end
      end
      // all-zero row: missing context
      if (cum[3] == '0) begin
         code = CODE_N;
      end
   end

endmodule

// ===== hw/rtl/markov_kmer_sequence_generator.sv =====
// top level of the order-k markov k-mer sequence generator
//
// Order-K Markov generator of nucleotide codes. The transition table lives
// in one synchronous ram with one row of four weights per K-base context.
// After reset the block sweeps the table to zero, one row per cycle;
// during that pass no request beat is taken, register writes are. A
// request beat is either a load (one weight written into the table by
// read-modify-write of its row) or a generate (the row of the current
// history is read and a base is picked by exact integer compare). For
// every request the accept cycle in ST_IDLE launches the ram read, and
// ST_EXEC uses the read data and writes back or updates the chain.
// The chain is bound by that ram read, since the next row address is the
// base just picked. A finished base waits in an output register, so the
// next request is accepted while it is still pending; only a generate that
// must emit while that register is still full waits for it to drain.
// Missing rows give N and lock the chain at N; after burnin_count discarded
// bases, out_length bases are emitted and then the block stays silent.
module markov_kmer_sequence_generator import mksg_pkg::*; #(
   parameter int ORDER_K     = 4,
   parameter int WEIGHT_BITS = 16,
   parameter int DRAW_BITS   = 32
) (
   input  logic       clock,
   input  logic       reset,
   mksg_req_if.sink   req_bus,
   mksg_rsp_if.source rsp_bus,
   mksg_cfg_if.sink   csr_bus
);

   localparam int ROW_BITS = 2 * ORDER_K;
   localparam int NUM_ROWS = 1 << ROW_BITS;
   localparam int RAM_BITS = 4 * WEIGHT_BITS;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   // control state
   state_type           state_ff, state_in;
   logic [ROW_BITS-1:0] clr_addr_ff, clr_addr_in;
   logic                started_ff, started_in;
   logic                stuck_ff, stuck_in;
   logic [31:0]         discard_ff, discard_in;
   logic [31:0]         emitted_ff, emitted_in;
   logic [ROW_BITS-1:0] history_ff, history_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // registers
   logic [7:0]  start_kmer_ff;
   logic [31:0] burnin_ff;
   logic [31:0] out_length_ff;

   // captured request beat and result payload
   logic                   act_ff, act_in;
   logic [ROW_BITS-1:0]    addr_ff, addr_in;
   logic [1:0]             col_ff, col_in;
   logic [WEIGHT_BITS-1:0] weight_ff, weight_in;
   logic [DRAW_BITS-1:0]   draw_ff, draw_in;
   logic [CODE_BITS-1:0]   rsp_code_ff, rsp_code_in;
   logic                   rsp_last_ff, rsp_last_in;

   // ram ports
   logic                ram_we;
   logic [ROW_BITS-1:0] ram_waddr;
   logic [RAM_BITS-1:0] ram_wdata;
   logic [ROW_BITS-1:0] ram_raddr;
   logic [RAM_BITS-1:0] ram_rdata;

   logic [CODE_BITS-1:0] pick_code;
   logic                 out_free;

   mksg_ram #(
      .WIDTH (RAM_BITS),
      .DEPTH (NUM_ROWS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   mksg_pick #(
      .WEIGHT_BITS (WEIGHT_BITS),
      .DRAW_BITS   (DRAW_BITS)
   ) u_pick (
      .row  (ram_rdata),
      .draw (draw_ff),
      .code (pick_code)
   );

   // register writes are always taken
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_kmer_ff <= '0;
         burnin_ff     <= '0;
         out_length_ff <= '0;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_START_KMER:   start_kmer_ff <= csr_bus.data[7:0];
            CSR_BURNIN_COUNT: burnin_ff     <= csr_bus.data;
            CSR_OUT_LENGTH:   out_length_ff <= csr_bus.data;
            default:          ;
         endcase
      end
   end

   // the output slot frees up in the same cycle it is drained
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      logic produce;
      logic [CODE_BITS-1:0] base;

      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      started_in   = started_ff;
      stuck_in     = stuck_ff;
      discard_in   = discard_ff;
      emitted_in   = emitted_ff;
      history_in   = history_ff;
      act_in       = act_ff;
      addr_in      = addr_ff;
      col_in       = col_ff;
      weight_in    = weight_ff;
      draw_in      = draw_ff;
      rsp_code_in  = rsp_code_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;

      req_bus.ready = 1'b0;
      ram_we        = 1'b0;
      ram_waddr     = addr_ff;
      ram_wdata     = ram_rdata;
      ram_raddr     = addr_ff;
      produce       = 1'b0;
      base          = stuck_ff ? CODE_N : pick_code;

      case (state_ff)
         ST_CLEAR: begin
            // zero one row per cycle
            ram_we      = 1'b1;
            ram_waddr   = clr_addr_ff;
            ram_wdata   = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == ROW_BITS'(NUM_ROWS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_bus.ready = 1'b1;
            // launch the row read with the beat itself
            if (req_bus.action == ACT_GENERATE) begin
               ram_raddr = started_ff ? history_ff : ROW_BITS'(start_kmer_ff);
            end else begin
               ram_raddr = ROW_BITS'(req_bus.row_index);
            end
            if (req_bus.valid) begin
               act_in    = req_bus.action;
               addr_in   = ram_raddr;
               col_in    = req_bus.base_index;
               weight_in = req_bus.weight[WEIGHT_BITS-1:0];
               draw_in   = req_bus.random_draw[DRAW_BITS-1:0];
               // first generate samples the start k-mer and burn-in
               if (req_bus.action == ACT_GENERATE && !started_ff) begin
                  started_in = 1'b1;
                  history_in = ROW_BITS'(start_kmer_ff);
                  discard_in = burnin_ff;
               end
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (act_ff == ACT_LOAD) begin
               // replace one column of the row just read
               ram_we = 1'b1;
               for (int c = 0; c < 4; c++) begin
                  if (col_ff == 2'(c)) begin
                     ram_wdata[c*WEIGHT_BITS +: WEIGHT_BITS] = weight_ff;
                  end
               end
               state_in = ST_IDLE;
            end else if (emitted_ff >= out_length_ff) begin
               // output done: no beat, no change to the chain, back to idle
               state_in = ST_IDLE;
            end else begin
               produce = (discard_ff == '0);
               if (!produce || out_free) begin
                  if (base == CODE_N) begin
                     stuck_in = 1'b1;
                  end else begin
                     history_in = ROW_BITS'({history_ff, base[1:0]});
                  end
                  if (produce) begin
                     emitted_in   = emitted_ff + 32'd1;
                     rsp_valid_in = 1'b1;
                     rsp_code_in  = base;
                     rsp_last_in  = ((emitted_ff + 32'd1) == out_length_ff);
                  end else begin
                     discard_in = discard_ff - 32'd1;
                  end
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         started_ff   <= 1'b0;
         stuck_ff     <= 1'b0;
         discard_ff   <= '0;
         emitted_ff   <= '0;
         history_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         started_ff   <= started_in;
         stuck_ff     <= stuck_in;
         discard_ff   <= discard_in;
         emitted_ff   <= emitted_in;
         history_ff   <= history_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff      <= act_in;
      addr_ff     <= addr_in;
      col_ff      <= col_in;
      weight_ff   <= weight_in;
      draw_ff     <= draw_in;
      rsp_code_ff <= rsp_code_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.base_code = rsp_code_ff;
   assign rsp_bus.last_base = rsp_last_ff;

endmodule
